// File: rtl/bpfs_pkg.sv
// Shared types and constants for the bit-packed field store.
// No dependencies; bpfs_front, bpfs_back, the top and the testbench take from here by scoped names.
package bpfs_pkg;

   localparam int WORD_BITS = 64;
   localparam int OFF_W     = 6;
   localparam int VALUE_W   = 63;
   localparam int ROW_W     = 16;
   localparam int WIDTH_W   = 6;
   localparam int APPEND_W  = 17;
   localparam int POS_W     = 22;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd16;

   // request actions
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // command kinds handed from front to back
   localparam logic [1:0] CMD_REPLY = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [ROW_W-1:0]   row;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value_res;
      logic [ROW_W-1:0]   row_res;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [POS_W-1:0]   pos;
      logic [WIDTH_W-1:0] width;
      logic [VALUE_W-1:0] value;
      logic [ROW_W-1:0]   row_res;
      logic               status;
   } cmd_type;

endpackage

// File: rtl/bpfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// File: rtl/bpfs_fifo.sv
// Small register-based queue used between the stages and on the result side.
// No dependencies.
module bpfs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? next_ptr(wr_ff) : wr_ff;
      rd_in    = do_pop ? next_ptr(rd_ff) : rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/bpfs_front.sv
// Front end: holds the item-width register and append row, classifies requests.
// Depends on bpfs_pkg.
module bpfs_front #(
   parameter int STORE_WORDS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [bpfs_pkg::WIDTH_W-1:0]    csr_wdata,
   input  logic                            req_take,
   input  bpfs_pkg::req_type               req_item,
   output bpfs_pkg::cmd_type               cmd
);

   localparam logic [23:0] CAP = 24'(STORE_WORDS * bpfs_pkg::WORD_BITS);

   logic [bpfs_pkg::WIDTH_W-1:0]  bits_ff, bits_in;
   logic [bpfs_pkg::APPEND_W-1:0] append_ff, append_in;
   logic [bpfs_pkg::APPEND_W-1:0] row_sel;
   logic [22:0]                   pos_full;
   logic [23:0]                   end_pos;
   logic                          fits;
   logic                          ok;

   assign row_sel  = (req_item.action == bpfs_pkg::ACT_APPEND) ? append_ff
                                                               : {1'b0, req_item.row};
   assign pos_full = 23'(row_sel) * 23'(bits_ff);
   assign end_pos  = 24'(pos_full) + 24'(bits_ff);
   assign fits     = (end_pos <= CAP);

   always_comb begin
      ok          = fits;
      cmd.pos     = pos_full[bpfs_pkg::POS_W-1:0];
      cmd.width   = bits_ff;
      cmd.value   = req_item.value;
      cmd.row_res = req_item.row;
      cmd.status  = !fits;
      cmd.kind    = bpfs_pkg::CMD_REPLY;
      append_in   = append_ff;
      case (req_item.action)
         bpfs_pkg::ACT_WRITE: begin
            if (fits && bits_ff != '0) begin
               cmd.kind = bpfs_pkg::CMD_WRITE;
            end
         end
         bpfs_pkg::ACT_APPEND: begin
            // fail once the append row has run past the row range
            ok          = fits && !append_ff[bpfs_pkg::APPEND_W-1];
            cmd.status  = !ok;
            cmd.row_res = append_ff[bpfs_pkg::APPEND_W-1] ? '1
                                                          : append_ff[bpfs_pkg::ROW_W-1:0];
            if (ok && bits_ff != '0) begin
               cmd.kind = bpfs_pkg::CMD_WRITE;
            end
            if (req_take && ok) begin
               append_in = append_ff + 1'b1;
            end
         end
         bpfs_pkg::ACT_READ: begin
            if (fits && bits_ff != '0) begin
               cmd.kind = bpfs_pkg::CMD_READ;
            end
         end
         bpfs_pkg::ACT_CLEAR: begin
            cmd.kind    = bpfs_pkg::CMD_CLEAR;
            cmd.row_res = '0;
            cmd.status  = 1'b0;
            if (req_take) begin
               append_in = '0;
            end
         end
         default: begin
            cmd.kind = bpfs_pkg::CMD_REPLY;
         end
      endcase
      bits_in = csr_wen ? csr_wdata : bits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff   <= bpfs_pkg::WIDTH_RESET;
         append_ff <= '0;
      end else begin
         bits_ff   <= bits_in;
         append_ff <= append_in;
      end
   end

endmodule

// File: rtl/bpfs_back.sv
// Back end: executes commands against two word banks (even and odd words),
// read-modify-write of up to two adjacent words, and the zeroing sweep.
// Depends on bpfs_pkg and bpfs_ram.
module bpfs_back #(
   parameter int STORE_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  bpfs_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output bpfs_pkg::rsp_type rsp,
   output logic              init_busy
);

   localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int WIW        = bpfs_pkg::POS_W - bpfs_pkg::OFF_W;
   localparam logic [BAW-1:0] LAST_ADDR = BAW'(BANK_DEPTH - 1);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MODIFY = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [BAW-1:0]               sweep_ff, sweep_in;
   logic                         sweeping;
   logic [WIW-1:0]               word;
   logic [WIW:0]                 word_up;
   logic [bpfs_pkg::OFF_W-1:0]   off;
   logic                         hi_is_odd;
   logic [BAW-1:0]               even_addr, odd_addr;
   logic                         rd_en;
   logic                         even_we, odd_we;
   logic                         wr_words;
   logic [63:0]                  even_q, odd_q;
   logic [63:0]                  even_wd, odd_wd;
   logic [127:0]                 old_pair, mask, ins, merged, got;
   logic [63:0]                  m64;
   logic [7:0]                   sh;
   logic                         straddle;
   logic [bpfs_pkg::VALUE_W-1:0] rd_val;

   // address both words of the pair; the even bank holds the upper word when
   // the item starts in an even word
   assign word      = cmd.pos[bpfs_pkg::POS_W-1:bpfs_pkg::OFF_W];
   assign off       = cmd.pos[bpfs_pkg::OFF_W-1:0];
   assign hi_is_odd = word[0];
   assign word_up   = {1'b0, word} + (WIW + 1)'(word[0]);
   assign even_addr = word_up[BAW:1];
   assign odd_addr  = word[BAW:1];

   assign straddle = (7'(off) + 7'(cmd.width)) > 7'd64;
   assign sh       = 8'd128 - 8'(off) - 8'(cmd.width);
   assign m64      = (64'd1 << cmd.width) - 64'd1;
   assign old_pair = hi_is_odd ? {odd_q, even_q} : {even_q, odd_q};
   assign mask     = {64'd0, m64} << sh;
   assign ins      = {64'd0, m64 & {1'b0, cmd.value}} << sh;
   assign merged   = (old_pair & ~mask) | ins;
   assign got      = old_pair >> sh;
   assign rd_val   = got[bpfs_pkg::VALUE_W-1:0] & m64[bpfs_pkg::VALUE_W-1:0];

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      sweeping = 1'b0;
      rd_en    = 1'b0;
      wr_words = 1'b0;
      rsp_push = 1'b0;
      cmd_pop  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            sweeping = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.kind)
                  bpfs_pkg::CMD_WRITE, bpfs_pkg::CMD_READ: begin
                     rd_en    = 1'b1;
                     state_in = ST_MODIFY;
                  end
                  bpfs_pkg::CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     if (!rsp_full) begin
                        rsp_push = 1'b1;
                        cmd_pop  = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            if (!rsp_full) begin
               wr_words = (cmd.kind == bpfs_pkg::CMD_WRITE);
               rsp_push = 1'b1;
               cmd_pop  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            sweeping = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               cmd_pop  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      even_we = sweeping || (wr_words && (hi_is_odd ? straddle : 1'b1));
      odd_we  = sweeping || (wr_words && (hi_is_odd ? 1'b1 : straddle));
      even_wd = sweeping ? 64'd0 : (hi_is_odd ? merged[63:0] : merged[127:64]);
      odd_wd  = sweeping ? 64'd0 : (hi_is_odd ? merged[127:64] : merged[63:0]);
      rsp.value_res = (cmd.kind == bpfs_pkg::CMD_READ) ? rd_val : '0;
      rsp.row_res   = cmd.row_res;
      rsp.status    = cmd.status;
   end

   assign init_busy = (state_ff == ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   bpfs_ram #(
      .WIDTH (bpfs_pkg::WORD_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (sweeping ? sweep_ff : even_addr),
      .wr_data (even_wd),
      .rd_en   (rd_en),
      .rd_addr (even_addr),
      .rd_data (even_q)
   );

   bpfs_ram #(
      .WIDTH (bpfs_pkg::WORD_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (sweeping ? sweep_ff : odd_addr),
      .wr_data (odd_wd),
      .rd_en   (rd_en),
      .rd_addr (odd_addr),
      .rd_data (odd_q)
   );

`ifndef ASSERT_OFF
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from an empty queue");

   a_modify_after_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_MODIFY))
      else $error("modify entered without a preceding read");

   a_init_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> (!rsp_push && !cmd_pop && !rd_en))
      else $error("activity during the reset sweep");
`endif

endmodule

// File: rtl/bit_packed_field_store.sv
// Write and read results pass through the command queue, the bank read and
// the modify step into the result queue; an out-of-range request or zero-width
// item is answered without a bank access. The back end takes one command at a
// time, doing the read-modify-write of the even/odd word banks; clear sweeps them.
// Reset: synchronous; full stays high while the banks are zeroed; the width
// resets to 16.
module bit_packed_field_store #(
   parameter int STORE_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         push,
   output logic                         full,
   input  bpfs_pkg::req_type            req_item,
   // result side
   output logic                         empty,
   input  logic                         pop,
   output bpfs_pkg::rsp_type            rsp_item,
   // item-width register
   input  logic                         csr_wen,
   input  logic [bpfs_pkg::WIDTH_W-1:0] csr_wdata
);

   bpfs_pkg::cmd_type cmd_new;
   bpfs_pkg::cmd_type cmd_head;
   bpfs_pkg::rsp_type rsp_new;
   logic [$bits(bpfs_pkg::cmd_type)-1:0] cmdq_rdata;
   logic [$bits(bpfs_pkg::rsp_type)-1:0] rspq_rdata;
   logic cmdq_full, cmdq_empty, cmdq_pop;
   logic rspq_full, rsp_push;
   logic init_busy;
   logic req_take;

   // Hold off requests while the command queue is full or the banks are
   // still being zeroed after reset.
   assign full     = cmdq_full || init_busy;
   assign req_take = push && !full;

   // Front: classify the request, resolve the append row and range check.
   bpfs_front #(
      .STORE_WORDS (STORE_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_take  (req_take),
      .req_item  (req_item),
      .cmd       (cmd_new)
   );

   // Decouple front from back so each can stall on its own.
   bpfs_fifo #(
      .WIDTH ($bits(bpfs_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_take),
      .wdata (cmd_new),
      .full  (cmdq_full),
      .pop   (cmdq_pop),
      .rdata (cmdq_rdata),
      .empty (cmdq_empty)
   );

   assign cmd_head = bpfs_pkg::cmd_type'(cmdq_rdata);

   // Back: access the banks and produce one result per command.
   bpfs_back #(
      .STORE_WORDS (STORE_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_empty (cmdq_empty),
      .cmd_pop   (cmdq_pop),
      .rsp_full  (rspq_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new),
      .init_busy (init_busy)
   );

   // Result queue: the back keeps working while a finished transfer waits.
   bpfs_fifo #(
      .WIDTH ($bits(bpfs_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rspq_full),
      .pop   (pop),
      .rdata (rspq_rdata),
      .empty (empty)
   );

   assign rsp_item = bpfs_pkg::rsp_type'(rspq_rdata);

endmodule

// File: dv/bit_packed_field_store_tb.sv
// Self-checking testbench for bit_packed_field_store: directed and random traffic
// through both queue ports, replies checked against an in-bench bit-level predictor.
// Depends on rtl/bpfs_pkg.sv and rtl/bit_packed_field_store.sv.
module bit_packed_field_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS   = bpfs_pkg::WORD_BITS;
   localparam int VALUE_W     = bpfs_pkg::VALUE_W;
   localparam int ROW_W       = bpfs_pkg::ROW_W;
   localparam int WIDTH_W     = bpfs_pkg::WIDTH_W;
   localparam int STORE_WORDS = 1024;
   localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
   localparam int ROW_SPAN    = 65536;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 push      = 1'b0;
   logic                 full;
   bpfs_pkg::req_type    req_item  = '0;
   logic                 empty;
   logic                 pop       = 1'b0;
   bpfs_pkg::rsp_type    rsp_item;
   logic                 csr_wen   = 1'b0;
   logic [WIDTH_W-1:0]   csr_wdata = '0;

   // Mirror of the block's state, advanced once per accepted transfer.
   logic [WORD_BITS-1:0] store_words [STORE_WORDS];
   int unsigned          next_append = 0;
   logic [WIDTH_W-1:0]   item_bits   = bpfs_pkg::WIDTH_RESET;

   // Replies still owed by the block, oldest first.
   bpfs_pkg::rsp_type    pending_replies [$];
   bpfs_pkg::rsp_type    want_reply;

   int unsigned          error_count = 0;
   int unsigned          pop_hold    = 0;
   bit                   gaps_on     = 1'b1;
   bit                   stall_on    = 1'b1;

   bit_packed_field_store #(
      .STORE_WORDS(STORE_WORDS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      foreach (store_words[k]) store_words[k] = '0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // A row fits when its last bit still lies inside the store.
   function automatic bit row_fits(input longint unsigned row);
      longint unsigned w;
      w = item_bits;
      return row * w + w <= STORE_BITS;
   endfunction

   // Walk the item bit by bit: bit 0 of the packed stream is the MSB of word 0,
   // so an item that runs off the end of a word simply carries on in the next.
   function automatic void put_field(input int unsigned pos, input logic [VALUE_W-1:0] val);
      int unsigned w;
      int unsigned p;
      w = item_bits;
      for (int unsigned i = 0; i < w; i++) begin
         p = pos + i;
         store_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)] = val[w - 1 - i];
      end
   endfunction

   function automatic logic [VALUE_W-1:0] get_field(input int unsigned pos);
      logic [VALUE_W-1:0] val;
      int unsigned w;
      int unsigned p;
      val = '0;
      w = item_bits;
      for (int unsigned i = 0; i < w; i++) begin
         p = pos + i;
         val[w - 1 - i] = store_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)];
      end
      return val;
   endfunction

   // Apply one request to the mirror and return the reply it must produce.
   function automatic bpfs_pkg::rsp_type predict_reply(input bpfs_pkg::req_type req);
      bpfs_pkg::rsp_type rsp;
      rsp = '0;
      case (req.action)
         bpfs_pkg::ACT_WRITE: begin
            rsp.row_res = req.row;
            if (row_fits(req.row)) put_field(32'(req.row) * 32'(item_bits), req.value);
            else rsp.status = 1'b1;
         end
         bpfs_pkg::ACT_APPEND: begin
            // the reported row saturates once the counter has run past the row range
            rsp.row_res = (next_append >= ROW_SPAN) ? '1 : ROW_W'(next_append);
            if (next_append < ROW_SPAN && row_fits(next_append)) begin
               put_field(next_append * 32'(item_bits), req.value);
               next_append++;
            end else begin
               rsp.status = 1'b1;
            end
         end
         bpfs_pkg::ACT_READ: begin
            rsp.row_res = req.row;
            if (row_fits(req.row)) rsp.value_res = get_field(32'(req.row) * 32'(item_bits));
            else rsp.status = 1'b1;
         end
         default: begin
            foreach (store_words[k]) store_words[k] = '0;
            next_append = 0;
         end
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Transfer monitors and result checking
   // ---------------------------------------------------------------------

   // Predict at the edge that takes the request; all ports are driven by
   // nonblocking assignments, so the values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && push && !full)
         pending_replies.insert(pending_replies.size(), predict_reply(req_item));
   end

   // Compare every reply taken with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_replies.size() == 0) begin
            error_count++;
            $display("%0t: reply with nothing outstanding, expected none, actual %0h",
                     $time, rsp_item);
         end else begin
            want_reply = pending_replies.pop_front();
            if (rsp_item.value_res !== want_reply.value_res) begin
               error_count++;
               $display("%0t: value_res mismatch, expected %0h, actual %0h",
                        $time, want_reply.value_res, rsp_item.value_res);
            end
            if (rsp_item.row_res !== want_reply.row_res) begin
               error_count++;
               $display("%0t: row_res mismatch, expected %0d, actual %0d",
                        $time, want_reply.row_res, rsp_item.row_res);
            end
            if (rsp_item.status !== want_reply.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0b, actual %0b",
                        $time, want_reply.status, rsp_item.status);
            end
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Result side: hold pop low for random stretches while stalling is enabled,
   // otherwise drain every cycle.
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         pop      <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
         pop      <= 1'b0;
         pop_hold <= pick_gap();
      end else begin
         pop      <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------

   // Present one request and hold it until the block takes it. Leave push high
   // when no gap follows, so back-to-back transfers need no extra assignment.
   task automatic send_req(input logic [1:0] act, input logic [ROW_W-1:0] row,
                           input logic [VALUE_W-1:0] val);
      int unsigned gap;
      req_item <= '{action: act, row: row, value: val};
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop push, then wait until every reply is in and the block is ready again.
   // The first edge lets the request monitor catch up with the last transfer.
   task automatic drain_replies(input int unsigned settle);
      push <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0 || full) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write the item width while the block is idle; the mirror follows at once.
   task automatic set_item_bits(input logic [WIDTH_W-1:0] bits);
      drain_replies(3);
      csr_wen   <= 1'b1;
      csr_wdata <= bits;
      @(posedge clock);
      csr_wen   <= 1'b0;
      item_bits  = bits;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // The store must read back as zero straight out of reset, append from row 0.
   task automatic test_reset_state();
      send_req(bpfs_pkg::ACT_READ, 16'd0, '0);
      send_req(bpfs_pkg::ACT_READ, 16'd4095, '0);
      send_req(bpfs_pkg::ACT_APPEND, 16'd0, VALUE_W'(63'h1357));
   endtask

   // Default width: masking of wide values, the last row that fits, rows just
   // past capacity and at the top of the row range, then a clear.
   task automatic test_default_width();
      send_req(bpfs_pkg::ACT_WRITE, 16'd0, '1);
      send_req(bpfs_pkg::ACT_READ, 16'd0, '0);
      send_req(bpfs_pkg::ACT_WRITE, 16'd3, VALUE_W'(63'h1234));
      send_req(bpfs_pkg::ACT_READ, 16'd3, '1);
      send_req(bpfs_pkg::ACT_WRITE, 16'd4095, VALUE_W'(63'h5A5A_0000_0000_A5A5));
      send_req(bpfs_pkg::ACT_READ, 16'd4095, '0);
      send_req(bpfs_pkg::ACT_WRITE, 16'd4096, '1);
      send_req(bpfs_pkg::ACT_READ, 16'd4096, '0);
      send_req(bpfs_pkg::ACT_WRITE, 16'hFFFF, '0);
      send_req(bpfs_pkg::ACT_CLEAR, 16'hFFFF, '1);
      send_req(bpfs_pkg::ACT_READ, 16'd0, '0);
   endtask

   // Widest items straddle words; narrowest reach the last row; zero-width
   // items store nothing and read as zero.
   task automatic test_width_extremes();
      set_item_bits(6'd63);
      send_req(bpfs_pkg::ACT_WRITE, 16'd1, '1);
      send_req(bpfs_pkg::ACT_READ, 16'd0, '0);
      send_req(bpfs_pkg::ACT_READ, 16'd1, '0);
      send_req(bpfs_pkg::ACT_READ, 16'd2, '0);
      send_req(bpfs_pkg::ACT_WRITE, 16'd1039, VALUE_W'(63'h4000_0000_0000_0001));
      send_req(bpfs_pkg::ACT_READ, 16'd1039, '0);
      send_req(bpfs_pkg::ACT_WRITE, 16'd1040, '1);
      set_item_bits(6'd1);
      send_req(bpfs_pkg::ACT_WRITE, 16'hFFFF, VALUE_W'(1));
      send_req(bpfs_pkg::ACT_READ, 16'hFFFF, '0);
      send_req(bpfs_pkg::ACT_READ, 16'hFFFE, '0);
      set_item_bits(6'd0);
      send_req(bpfs_pkg::ACT_WRITE, 16'hFFFF, '1);
      send_req(bpfs_pkg::ACT_READ, 16'hFFFF, '0);
      send_req(bpfs_pkg::ACT_APPEND, 16'd0, '1);
   endtask

   // Fill the store by appends at the widest setting until capacity refuses
   // them; a refused append must not advance, and a narrower width resumes.
   task automatic test_append_capacity();
      set_item_bits(6'd63);
      send_req(bpfs_pkg::ACT_CLEAR, 16'd0, '0);
      for (int n = 0; n < 1040; n++)
         send_req(bpfs_pkg::ACT_APPEND, 16'd0, VALUE_W'({$urandom, $urandom}));
      send_req(bpfs_pkg::ACT_APPEND, 16'd0, '1);
      send_req(bpfs_pkg::ACT_APPEND, 16'd0, '1);
      send_req(bpfs_pkg::ACT_READ, 16'd1039, '0);
      set_item_bits(6'd1);
      send_req(bpfs_pkg::ACT_APPEND, 16'd0, VALUE_W'(1));
      send_req(bpfs_pkg::ACT_READ, 16'd1040, '0);
   endtask

   // Random traffic over several widths. Most rows land inside capacity and
   // reads favour rows written recently, so data actually round-trips; a few
   // rows sit on the capacity edge or anywhere in the row range.
   task automatic test_random_traffic();
      logic [WIDTH_W-1:0] phase_bits [8];
      int unsigned        recent_rows [$];
      int unsigned        cap_rows;
      int unsigned        row;
      int unsigned        pick;
      logic [1:0]         act;
      logic [VALUE_W-1:0] val;
      phase_bits[0] = 6'd1;
      phase_bits[1] = 6'd63;
      phase_bits[2] = bpfs_pkg::WIDTH_RESET;
      for (int k = 3; k < 8; k++) phase_bits[k] = WIDTH_W'($urandom_range(2, 62));
      for (int ph = 0; ph < 8; ph++) begin
         set_item_bits(phase_bits[ph]);
         // leave some phases free of idling on one side or both
         gaps_on  = (ph % 3) != 2;
         stall_on = (ph % 4) != 3;
         cap_rows = STORE_BITS / phase_bits[ph];
         recent_rows.delete();
         for (int n = 0; n < 70; n++) begin
            pick = $urandom_range(0, 99);
            act  = (pick < 36) ? bpfs_pkg::ACT_WRITE : (pick < 56) ? bpfs_pkg::ACT_APPEND :
                   (pick < 98) ? bpfs_pkg::ACT_READ : bpfs_pkg::ACT_CLEAR;
            pick = $urandom_range(0, 99);
            if (pick < 10)
               row = $urandom_range(0, ROW_SPAN - 1);
            else if (pick < 15)
               row = (cap_rows >= ROW_SPAN || $urandom_range(0, 1)) ? cap_rows - 1 : cap_rows;
            else if (act == bpfs_pkg::ACT_READ && recent_rows.size() != 0 && pick < 60)
               row = recent_rows[$urandom_range(0, recent_rows.size() - 1)];
            else
               row = $urandom_range(0, cap_rows - 1);
            pick = $urandom_range(0, 9);
            val  = (pick == 0) ? '1 : (pick == 1) ? '0 : VALUE_W'({$urandom, $urandom});
            if (act == bpfs_pkg::ACT_WRITE) begin
               recent_rows.insert(recent_rows.size(), row);
               if (recent_rows.size() > 32) void'(recent_rows.pop_front());
            end
            if (act == bpfs_pkg::ACT_CLEAR) recent_rows.delete();
            send_req(act, ROW_W'(row), val);
         end
      end
      gaps_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // the block zeroes its banks after reset; send_req waits on full for that
      test_reset_state();
      test_default_width();
      test_width_extremes();
      test_append_capacity();
      test_random_traffic();
      drain_replies(10);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run with the longest gaps and stalls.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: bit_packed_field_store.f
rtl/bpfs_pkg.sv
rtl/bpfs_ram.sv
rtl/bpfs_fifo.sv
rtl/bpfs_front.sv
rtl/bpfs_back.sv
rtl/bit_packed_field_store.sv
dv/bit_packed_field_store_tb.sv
